FILE: sv/lcpe_pkg.sv
// shared types and constants of the led chain pwm bit encoder
package lcpe_pkg;

	localparam int LED_COUNT_DEF = 64;
	localparam int HALF_SLOTS    = 24;
	localparam int BUF_SLOTS     = 48;
	localparam int QUEUE_DEPTH   = 2;
	localparam int COLOUR_W      = 24;

	localparam logic [7:0] ZERO_DUTY_RST  = 8'd32;
	localparam logic [7:0] ONE_DUTY_RST   = 8'd64;
	localparam logic [7:0] LATCH_DUTY_RST = 8'd90;

	// input opcodes
	typedef enum logic [1:0] {
		OP_SET   = 2'd0,
		OP_START = 2'd1,
		OP_EVENT = 2'd2,
		OP_CLEAR = 2'd3
	} opcode_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_ZERO_DUTY  = 2'd0,
		REG_ONE_DUTY   = 2'd1,
		REG_LATCH_DUTY = 2'd2
	} reg_index_t;

	// classified work for the back end
	typedef enum logic [2:0] {
		CMD_SET,
		CMD_CLEAR,
		CMD_START,
		CMD_LATCH,
		CMD_STOP,
		CMD_EXPAND
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t             kind;
		logic [7:0]            idx;
		logic [COLOUR_W-1:0]   colour;
		logic                  busy;
	} cmd_t;

	typedef struct packed {
		logic [7:0] zero_duty;
		logic [7:0] one_duty;
		logic [7:0] latch_duty;
	} cfg_regs_t;

	// back end sequencer states
	typedef enum logic [1:0] {
		B_IDLE,
		B_LOAD,
		B_EMIT
	} back_state_t;

endpackage

FILE: sv/lcpe_ram.sv
// generic single-port-write ram with registered read
module lcpe_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: sv/lcpe_front.sv
// front end: accepts items, tracks led position and busy, classifies work
module lcpe_front #(
	parameter int LED_COUNT = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           in_opcode,
	input  logic [7:0]           in_idx,
	input  logic [23:0]          in_colour,
	input  logic                 q_full,
	output logic                 q_push,
	output lcpe_pkg::cmd_t       q_cmd
);
	import lcpe_pkg::*;

	localparam logic [7:0] CNT = 8'(LED_COUNT);

	logic [7:0] pos_q;
	logic       busy_q;
	logic       accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// classify the incoming item
	always_comb begin
		q_cmd        = '0;
		q_cmd.kind   = CMD_SET;
		q_cmd.idx    = in_idx;
		q_cmd.colour = in_colour;
		q_cmd.busy   = busy_q;
		q_push       = 1'b0;
		case (opcode_t'(in_opcode))
			OP_SET: begin
				q_push = accept && (in_idx < CNT);
			end
			OP_CLEAR: begin
				q_cmd.kind = CMD_CLEAR;
				q_push     = accept;
			end
			OP_START: begin
				q_cmd.kind = CMD_START;
				q_cmd.busy = 1'b1;
				q_push     = accept;
			end
			OP_EVENT: begin
				q_push = accept;
				if (pos_q > CNT) begin
					q_cmd.kind = CMD_STOP;
					q_cmd.busy = 1'b0;
				end else if (pos_q == CNT) begin
					q_cmd.kind = CMD_LATCH;
				end else begin
					q_cmd.kind = CMD_EXPAND;
					q_cmd.idx  = pos_q;
				end
			end
			default: begin
				q_push = 1'b0;
			end
		endcase
	end

	// led position and busy tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			busy_q <= 1'b0;
		end else if (accept) begin
			if (opcode_t'(in_opcode) == OP_START) begin
				pos_q  <= '0;
				busy_q <= 1'b1;
			end else if (opcode_t'(in_opcode) == OP_EVENT) begin
				if (pos_q > CNT) begin
					busy_q <= 1'b0;
				end else begin
					pos_q <= pos_q + 8'd1;
				end
			end
		end
	end

endmodule

FILE: sv/lcpe_queue.sv
// short command queue between front and back
module lcpe_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lcpe_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output lcpe_pkg::cmd_t pop_cmd
);
	import lcpe_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [PW:0] DEPTH_C = (PW + 1)'(QUEUE_DEPTH);
	localparam logic [PW-1:0] LAST_P = PW'(QUEUE_DEPTH - 1);

	cmd_t          buf_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [PW:0]   cnt_q;

	assign full    = (cnt_q == DEPTH_C);
	assign empty   = (cnt_q == '0);
	assign pop_cmd = buf_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push && !full) begin
			buf_q[wr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= (wr_q == LAST_P) ? '0 : wr_q + PW'(1);
			end
			if (pop && !empty) begin
				rd_q <= (rd_q == LAST_P) ? '0 : rd_q + PW'(1);
			end
			case ({push && !full, pop && !empty})
				2'b10:   cnt_q <= cnt_q + (PW + 1)'(1);
				2'b01:   cnt_q <= cnt_q - (PW + 1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: sv/lcpe_back.sv
// back end: colour store and duty sequencer with output register
module lcpe_back #(
	parameter int LED_COUNT = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  lcpe_pkg::cmd_t      q_cmd,
	output logic                q_pop,
	input  lcpe_pkg::cfg_regs_t cfg,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [5:0]          out_slot,
	output logic [7:0]          out_duty,
	output logic                out_stop,
	output logic                out_busy,
	output logic                out_last
);
	import lcpe_pkg::*;

	localparam int AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

	back_state_t   state_q;
	back_state_t   state_d;
	cmd_t          cmd_q;
	logic [5:0]    cnt_q;
	logic [23:0]   colour_q;
	logic          hit_q;
	logic          valid_q [LED_COUNT];
	logic [23:0]   rdata;
	logic          emit;
	logic          done;
	logic          ram_we;
	logic          ram_re;
	logic [AW-1:0] addr;
	logic [5:0]    total;
	logic [5:0]    slot_d;
	logic [7:0]    duty_d;

	assign addr = q_cmd.idx[AW-1:0];

	lcpe_ram #(
		.WIDTH(COLOUR_W),
		.DEPTH(LED_COUNT),
		.AW   (AW)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(addr),
		.wdata(q_cmd.colour),
		.re   (ram_re),
		.raddr(addr),
		.rdata(rdata)
	);

	// result count and payload of the current command
	always_comb begin
		total  = 6'(BUF_SLOTS);
		slot_d = cnt_q;
		duty_d = 8'd0;
		case (cmd_q.kind)
			CMD_LATCH: duty_d = cfg.latch_duty;
			CMD_STOP:  total  = 6'd1;
			CMD_EXPAND: begin
				total  = 6'(HALF_SLOTS);
				slot_d = cmd_q.idx[0] ? cnt_q + 6'(HALF_SLOTS) : cnt_q;
				duty_d = colour_q[23] ? cfg.one_duty : cfg.zero_duty;
			end
			default: duty_d = 8'd0;
		endcase
	end

	assign done = (cnt_q == total - 6'd1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					case (q_cmd.kind)
						CMD_SET, CMD_CLEAR: state_d = B_IDLE;
						CMD_EXPAND:         state_d = B_LOAD;
						default:            state_d = B_EMIT;
					endcase
				end
			end
			B_LOAD:  state_d = B_EMIT;
			B_EMIT: begin
				if (emit && done) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		q_pop  = 1'b0;
		emit   = 1'b0;
		ram_we = 1'b0;
		ram_re = 1'b0;
		case (state_q)
			B_IDLE: begin
				q_pop  = !q_empty;
				ram_we = !q_empty && (q_cmd.kind == CMD_SET);
				ram_re = !q_empty && (q_cmd.kind == CMD_EXPAND);
			end
			B_EMIT:  emit = !out_valid || out_ready;
			default: emit = 1'b0;
		endcase
	end

	// control state and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			cnt_q     <= '0;
			out_valid <= 1'b0;
			for (int i = 0; i < LED_COUNT; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				cnt_q <= '0;
				if (q_cmd.kind == CMD_SET) begin
					valid_q[addr] <= 1'b1;
				end else if (q_cmd.kind == CMD_CLEAR) begin
					for (int i = 0; i < LED_COUNT; i++) begin
						valid_q[i] <= 1'b0;
					end
				end
			end else if (emit) begin
				cnt_q <= cnt_q + 6'd1;
			end
			if (emit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// command, colour and result payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
			hit_q <= valid_q[addr];
		end
		if (state_q == B_LOAD) begin
			colour_q <= hit_q ? rdata : '0;
		end else if (emit) begin
			colour_q <= {colour_q[22:0], 1'b0};
		end
		if (emit) begin
			out_slot <= slot_d;
			out_duty <= duty_d;
			out_stop <= (cmd_q.kind == CMD_STOP);
			out_busy <= cmd_q.busy;
			out_last <= done;
		end
	end

endmodule

FILE: sv/led_chain_pwm_bit_encoder.sv
// top level of the led chain pwm bit encoder
//
//  channel  | direction | handshake              | payload
//  s_axis   | in        | tvalid / tready        | tdata: index, red, green, blue; tuser: opcode
//  m_axis   | out       | tvalid / tready        | tdata: slot, duty, busy; tuser: stop; tlast
//  cfg      | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// the front takes one item a cycle into a two-entry command queue while it is not full
// back end: set and clear stay idle; start and latch give 48 items, one a cycle unless stalled;
// a led expansion gives 24 items after a colour store read and a load state, stop gives one
// reset empties the queue and marks every colour entry invalid (reads as zero)
// a stalled output holds the back end; the front keeps accepting until the queue fills
module led_chain_pwm_bit_encoder #(
	parameter int LED_COUNT = lcpe_pkg::LED_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // led_index[7:0], red[15:8], green[23:16], blue[31:24]
	input  logic [1:0]  s_axis_tuser,  // opcode[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // slot[5:0], duty[13:6], busy_res[14], zero[15]
	output logic        m_axis_tuser,  // stop_output[0]
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import lcpe_pkg::*;

	cfg_regs_t  cfg_q;
	cmd_t       push_cmd;
	cmd_t       pop_cmd;
	logic       push;
	logic       pop;
	logic       full;
	logic       empty;
	logic [5:0] slot;
	logic [7:0] duty;
	logic       busy;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.zero_duty  <= ZERO_DUTY_RST;
			cfg_q.one_duty   <= ONE_DUTY_RST;
			cfg_q.latch_duty <= LATCH_DUTY_RST;
		end else if (cfg_valid) begin
			case (reg_index_t'(cfg_index))
				REG_ZERO_DUTY:  cfg_q.zero_duty  <= cfg_data;
				REG_ONE_DUTY:   cfg_q.one_duty   <= cfg_data;
				REG_LATCH_DUTY: cfg_q.latch_duty <= cfg_data;
				default:        cfg_q <= cfg_q;
			endcase
		end
	end

	lcpe_front #(
		.LED_COUNT(LED_COUNT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_opcode(s_axis_tuser),
		.in_idx   (s_axis_tdata[7:0]),
		.in_colour({s_axis_tdata[23:16], s_axis_tdata[15:8], s_axis_tdata[31:24]}),
		.q_full   (full),
		.q_push   (push),
		.q_cmd    (push_cmd)
	);

	lcpe_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.full    (full),
		.pop     (pop),
		.empty   (empty),
		.pop_cmd (pop_cmd)
	);

	lcpe_back #(
		.LED_COUNT(LED_COUNT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (empty),
		.q_cmd    (pop_cmd),
		.q_pop    (pop),
		.cfg      (cfg_q),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_slot (slot),
		.out_duty (duty),
		.out_stop (m_axis_tuser),
		.out_busy (busy),
		.out_last (m_axis_tlast)
	);

	// result packing
	assign m_axis_tdata = {1'b0, busy, duty, slot};

endmodule

FILE: tb/lcpe_checker.sv
// checker of the led chain pwm bit encoder: watches the channels, predicts duty items, compares
`timescale 1ns / 1ps

module lcpe_checker #(
	parameter int LED_COUNT = lcpe_pkg::LED_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // led_index[7:0], red[15:8], green[23:16], blue[31:24]
	input  logic [1:0]  s_axis_tuser,  // opcode[1:0]
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,  // slot[5:0], duty[13:6], busy_res[14], zero[15]
	input  logic        m_axis_tuser,  // stop_output[0]
	input  logic        m_axis_tlast,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output int          pending,
	output int          errors,
	output int          checked
);
	import lcpe_pkg::*;

	localparam int AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

	typedef struct packed {
		logic [5:0] slot;
		logic [7:0] duty;
		logic       stop;
		logic       busy;
		logic       last;
	} duty_item_t;

	duty_item_t          duty_due [$];
	duty_item_t          want;
	duty_item_t          got;
	logic [COLOUR_W-1:0] colour_mem [LED_COUNT];
	logic [7:0]          led_pos;
	logic                busy_now;
	logic [7:0]          duty_zero;
	logic [7:0]          duty_one;
	logic [7:0]          duty_latch;
	int                  err_cnt;
	int                  match_cnt;

	function automatic void queue_duty(logic [5:0] slot, logic [7:0] duty, logic stop,
		logic busy, logic last);
		duty_item_t d;
		d.slot = slot;
		d.duty = duty;
		d.stop = stop;
		d.busy = busy;
		d.last = last;
		duty_due.push_back(d);
	endfunction

	// expected duty items of one accepted item, and the state it leaves
	function automatic void encode_item(opcode_t op, logic [31:0] data);
		logic [7:0]          idx;
		logic [COLOUR_W-1:0] colour;
		logic [5:0]          base;
		idx = data[7:0];
		case (op)
			OP_SET: begin
				// green, red, blue from high to low
				if (idx < LED_COUNT)
					colour_mem[idx[AW-1:0]] = {data[23:16], data[15:8], data[31:24]};
			end
			OP_CLEAR: begin
				foreach (colour_mem[i])
					colour_mem[i] = '0;
			end
			OP_START: begin
				busy_now = 1'b1;
				led_pos  = '0;
				for (int k = 0; k < BUF_SLOTS; k++)
					queue_duty(6'(k), 8'd0, 1'b0, 1'b1, k == BUF_SLOTS - 1);
			end
			OP_EVENT: begin
				if (led_pos > LED_COUNT) begin
					// past the latch slot: stop, position stays saturated
					busy_now = 1'b0;
					queue_duty(6'd0, 8'd0, 1'b1, 1'b0, 1'b1);
				end else if (led_pos == LED_COUNT) begin
					for (int k = 0; k < BUF_SLOTS; k++)
						queue_duty(6'(k), duty_latch, 1'b0, busy_now, k == BUF_SLOTS - 1);
					led_pos = 8'(LED_COUNT + 1);
				end else begin
					// msb first into the half picked by led parity
					colour = colour_mem[led_pos[AW-1:0]];
					base   = led_pos[0] ? 6'(HALF_SLOTS) : 6'd0;
					for (int k = 0; k < HALF_SLOTS; k++)
						queue_duty(base + 6'(k),
							colour[COLOUR_W - 1 - k] ? duty_one : duty_zero,
							1'b0, busy_now, k == HALF_SLOTS - 1);
					led_pos = led_pos + 8'd1;
				end
			end
			default: ;
		endcase
	endfunction

	// compare outputs, track config and inputs
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_due.delete();
			foreach (colour_mem[i])
				colour_mem[i] = '0;
			led_pos    = '0;
			busy_now   = 1'b0;
			duty_zero  = ZERO_DUTY_RST;
			duty_one   = ONE_DUTY_RST;
			duty_latch = LATCH_DUTY_RST;
			err_cnt    = 0;
			match_cnt  = 0;
			pending   <= 0;
			errors    <= 0;
			checked   <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = {m_axis_tdata[5:0], m_axis_tdata[13:6], m_axis_tuser,
					m_axis_tdata[14], m_axis_tlast};
				if (duty_due.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected item, expected none, got slot %0d duty %0d stop %0b busy %0b last %0b",
						$time, got.slot, got.duty, got.stop, got.busy, got.last);
				end else begin
					want = duty_due.pop_front();
					if (got !== want || m_axis_tdata[15] !== 1'b0) begin
						err_cnt++;
						$display("%0t: mismatch, expected slot %0d duty %0d stop %0b busy %0b last %0b pad 0",
							$time, want.slot, want.duty, want.stop, want.busy, want.last);
						$display("%0t:           got slot %0d duty %0d stop %0b busy %0b last %0b pad %0b",
							$time, got.slot, got.duty, got.stop, got.busy, got.last,
							m_axis_tdata[15]);
					end else begin
						match_cnt++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (reg_index_t'(cfg_index))
					REG_ZERO_DUTY:  duty_zero  = cfg_data;
					REG_ONE_DUTY:   duty_one   = cfg_data;
					REG_LATCH_DUTY: duty_latch = cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				encode_item(opcode_t'(s_axis_tuser), s_axis_tdata);
			pending <= duty_due.size();
			errors  <= err_cnt;
			checked <= match_cnt;
		end
	end

endmodule

FILE: tb/tb.sv
// testbench top of the led chain pwm bit encoder: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb;
	import lcpe_pkg::*;

	localparam int LED_COUNT   = LED_COUNT_DEF;
	localparam int ITEM_GOAL   = 250;
	localparam int CYCLE_LIMIT = 400000;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata  = '0;  // led_index[7:0], red[15:8], green[23:16], blue[31:24]
	logic [1:0]  s_axis_tuser  = OP_SET;  // opcode[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;  // slot[5:0], duty[13:6], busy_res[14], zero[15]
	logic        m_axis_tuser;  // stop_output[0]
	logic        m_axis_tlast;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index     = REG_ZERO_DUTY;
	logic [7:0]  cfg_data      = '0;

	int pending;
	int errors;
	int checked;
	int cycle_cnt  = 0;
	int items_sent = 0;
	int runs       = 0;
	int reg_writes = 0;
	int scene      = 0;
	bit calm       = 1'b0;

	led_chain_pwm_bit_encoder #(
		.LED_COUNT(LED_COUNT)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	lcpe_checker #(
		.LED_COUNT(LED_COUNT)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pending(pending),
		.errors(errors),
		.checked(checked)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// receiver stalls about 15 percent of the time unless calm
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= calm || ($urandom_range(0, 99) >= 15);
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("%0t: run did not finish within %0d cycles, %0d items still due",
				$time, CYCLE_LIMIT, pending);
			$display("FAIL");
			$finish;
		end
	end

	function automatic logic [31:0] pixel_word(logic [7:0] idx, logic [7:0] red,
		logic [7:0] green, logic [7:0] blue);
		return {blue, green, red, idx};
	endfunction

	// one item on the input stream, with an occasional gap before it
	task automatic send_item(opcode_t op, logic [31:0] data);
		if (!calm && $urandom_range(0, 99) < 15) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= data;
		do @(posedge clk); while (!s_axis_tready);
		if (!(op == OP_SET && data[7:0] >= LED_COUNT))
			items_sent++;
	endtask

	// set colour, now and then at an index the block ignores
	task automatic paint_random();
		logic [7:0] idx;
		if ($urandom_range(0, 9) == 0)
			idx = 8'($urandom_range(LED_COUNT, 255));
		else
			idx = 8'($urandom_range(0, LED_COUNT - 1));
		send_item(OP_SET, pixel_word(idx, 8'($urandom), 8'($urandom), 8'($urandom)));
	endtask

	// hold the sender until every duty item is out and the queue has settled
	task automatic wait_until_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(reg_index_t r, logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		reg_writes++;
	endtask

	function automatic logic [7:0] pick_duty();
		case ($urandom_range(0, 3))
			0:       return 8'd0;
			1:       return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	// duty settings: two extreme sets first, then random
	task automatic new_settings(int mode);
		if (mode == 0) begin
			write_reg(REG_ZERO_DUTY, 8'd0);
			write_reg(REG_ONE_DUTY, 8'd255);
			write_reg(REG_LATCH_DUTY, 8'd0);
		end else if (mode == 1) begin
			write_reg(REG_ZERO_DUTY, 8'd255);
			write_reg(REG_ONE_DUTY, 8'd0);
			write_reg(REG_LATCH_DUTY, 8'd255);
		end else begin
			write_reg(REG_ZERO_DUTY, pick_duty());
			write_reg(REG_ONE_DUTY, pick_duty());
			write_reg(REG_LATCH_DUTY, pick_duty());
		end
		cfg_valid <= 1'b0;
	endtask

	// colours, a start and a run of half-buffer events with some noise mixed in
	task automatic run_update(bit full_pass, bit hold_mid);
		int n_ev;
		int r;
		if ($urandom_range(0, 9) == 0)
			send_item(OP_CLEAR, $urandom);
		repeat ($urandom_range(4, 16)) paint_random();
		send_item(OP_START, $urandom);
		runs++;
		n_ev = full_pass ? LED_COUNT + 2 + $urandom_range(0, 3) : $urandom_range(1, 20);
		for (int e = 0; e < n_ev; e++) begin
			if (hold_mid && e == 10)
				wait_until_drained();
			r = $urandom_range(0, 99);
			if (r < 8)
				paint_random();
			else if (r < 10)
				send_item(OP_CLEAR, $urandom);
			else if (r < 12 && !full_pass)
				send_item(OP_START, $urandom);
			send_item(OP_EVENT, $urandom);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: event while idle, index extremes, set and clear during an update,
		// restart in the middle of an update
		send_item(OP_EVENT, 32'hFFFF_FFFF);
		send_item(OP_SET, pixel_word(8'd0, 8'hFF, 8'hFF, 8'hFF));
		send_item(OP_SET, pixel_word(8'd1, 8'h00, 8'h00, 8'h00));
		send_item(OP_SET, pixel_word(8'(LED_COUNT - 1), 8'h80, 8'h01, 8'h5A));
		send_item(OP_SET, pixel_word(8'(LED_COUNT), 8'hFF, 8'hFF, 8'hFF));
		send_item(OP_SET, pixel_word(8'd255, 8'hA5, 8'h3C, 8'hC3));
		send_item(OP_START, 32'h0000_0000);
		send_item(OP_EVENT, 32'h0000_0000);
		send_item(OP_EVENT, 32'hFFFF_FFFF);
		send_item(OP_CLEAR, 32'hFFFF_FFFF);
		send_item(OP_EVENT, 32'h0000_0000);
		send_item(OP_SET, pixel_word(8'd3, 8'h55, 8'hAA, 8'h0F));
		send_item(OP_EVENT, 32'h5555_5555);
		send_item(OP_START, 32'hAAAA_AAAA);
		send_item(OP_EVENT, 32'hAAAA_AAAA);

		// random updates, the first and third run through latch and stop
		while (items_sent < ITEM_GOAL) begin
			wait_until_drained();
			new_settings(scene);
			calm <= (scene == 2);
			run_update(scene == 0 || scene == 2 || $urandom_range(0, 2) == 0, scene == 1);
			scene++;
		end
		calm <= 1'b0;

		// let the last duty items drain, then watch for strays
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("drove %0d items over %0d update runs and %0d register writes",
			items_sent, runs, reg_writes);
		$display("%0d duty items matched, %0d mismatches", checked, errors);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
